FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/polyval_pkg.sv
// ----------------------------------------------------------------------------
// POLYVAL package
// Widths, register indexes, controller commands and the digit step function.
// ----------------------------------------------------------------------------
package polyval_pkg;

  localparam int WORD_W      = 64;
  localparam int BLOCK_W     = 2 * WORD_W;
  localparam int DIGIT_W     = 16;
  localparam int STEPS       = BLOCK_W / DIGIT_W;
  localparam int COUNT_W     = $clog2(STEPS);
  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = CFG_INDEX_W'(1);

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
    logic key_low_we;
    logic key_high_we;
  } cmd_t;

  // acc * x^-16 + d * b * x^-16 mod x^128 + x^127 + x^126 + x^121 + 1
  function automatic logic [BLOCK_W-1:0] gf_step(logic [BLOCK_W-1:0] acc,
                                                 logic [DIGIT_W-1:0] d,
                                                 logic [BLOCK_W-1:0] b);
    logic [BLOCK_W+DIGIT_W-1:0] t;
    logic [DIGIT_W-1:0]         q;
    logic [BLOCK_W-1:0]         r;
    t = {{DIGIT_W{1'b0}}, acc};
    for (int i = 0; i < DIGIT_W; i++) begin
      if (d[i]) begin
        t = t ^ ({{DIGIT_W{1'b0}}, b} << i);
      end
    end
    q = t[DIGIT_W-1:0];
    r = t[BLOCK_W+DIGIT_W-1:DIGIT_W]
        ^ {q, 112'b0}
        ^ {1'b0, q, 111'b0}
        ^ {2'b0, q, 110'b0}
        ^ {7'b0, q, 105'b0};
    return r;
  endfunction

endpackage

FILE: hdl/polyval_ctrl.sv
// ----------------------------------------------------------------------------
// POLYVAL controller
// Sequences load, eight multiply steps and digest hand-off; owns handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polyval_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                last_block,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [polyval_pkg::CFG_INDEX_W-1:0] cfg_index,
  output polyval_pkg::cmd_t                   cmd
);
  import polyval_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] count;
  logic               last;
  logic               out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    cmd             = '0;
    cmd.load        = in_valid && in_ready;
    cmd.step        = (state == S_RUN);
    cmd.emit        = (state == S_HOLD) && out_free;
    cmd.key_low_we  = cfg_valid && (cfg_index == REG_KEY_LOW);
    cmd.key_high_we = cfg_valid && (cfg_index == REG_KEY_HIGH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last  <= last_block;
            count <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          count <= count + COUNT_W'(1);
          if (count == COUNT_W'(STEPS - 1)) begin
            state <= last ? S_HOLD : S_IDLE;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_load, clk, rst, cmd.load, !in_ready)
  `ASSERT_NEXT(a_plain_block_done, clk, rst,
               cmd.step && (count == COUNT_W'(STEPS - 1)) && !last, in_ready)
  `ASSERT_NEXT(a_emit_sets_valid, clk, rst, cmd.emit, out_valid)
  `ASSERT_IMPLY(a_no_step_when_idle, clk, rst, in_ready, !cmd.step && !cmd.emit)

endmodule

FILE: hdl/polyval_dpath.sv
// ----------------------------------------------------------------------------
// POLYVAL datapath
// Key, accumulator, operand shifter, 16-bit digit multiply and digest register.
// ----------------------------------------------------------------------------
module polyval_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  polyval_pkg::cmd_t              cmd,
  input  logic [polyval_pkg::WORD_W-1:0] block_low,
  input  logic [polyval_pkg::WORD_W-1:0] block_high,
  input  logic [polyval_pkg::WORD_W-1:0] cfg_data,
  output logic [polyval_pkg::WORD_W-1:0] digest_low,
  output logic [polyval_pkg::WORD_W-1:0] digest_high
);
  import polyval_pkg::*;

  logic [WORD_W-1:0]  key_low;
  logic [WORD_W-1:0]  key_high;
  logic [BLOCK_W-1:0] acc;
  logic [BLOCK_W-1:0] opa;
  logic [BLOCK_W-1:0] acc_next;

  assign acc_next = gf_step(acc, opa[DIGIT_W-1:0], {key_high, key_low});

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      acc      <= '0;
    end else begin
      if (cmd.key_low_we) begin
        key_low <= cfg_data;
      end
      if (cmd.key_high_we) begin
        key_high <= cfg_data;
      end
      if (cmd.load) begin
        acc <= '0;
      end else if (cmd.step) begin
        acc <= acc_next;
      end else if (cmd.emit) begin
        acc <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opa <= acc ^ {block_high, block_low};
    end else if (cmd.step) begin
      opa <= opa >> DIGIT_W;
    end
    if (cmd.emit) begin
      digest_low  <= acc[WORD_W-1:0];
      digest_high <= acc[BLOCK_W-1:WORD_W];
    end
  end

endmodule

FILE: hdl/polyval_hash_accumulator_unit.sv
// ----------------------------------------------------------------------------
// POLYVAL hash accumulator unit
// RFC 8452 POLYVAL: acc = dot(acc ^ block, key), digest emitted on last block.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid/in_ready     block_low, block_high, last_block
//  out      out_valid/out_ready   digest_low, digest_high
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data (0 key low, 1 key high)
//
//  A request is accepted in S_IDLE and runs 8 multiply steps in S_RUN; a last
//  block then moves the accumulator into the digest register from S_HOLD.
//  The 8 steps are the 16-bit digit-serial carry-less multiply with reduction.
//  Reset clears key, accumulator and all handshake state.
//  A digest waiting on out_ready holds the next last block in its hand-off
//  cycle, and the input stalls until the waiting digest is taken.
//  cfg_ready is always high; writes to other indexes are dropped.
// ----------------------------------------------------------------------------
module polyval_hash_accumulator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [polyval_pkg::WORD_W-1:0]      block_low,
  input  logic [polyval_pkg::WORD_W-1:0]      block_high,
  input  logic                                last_block,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [polyval_pkg::WORD_W-1:0]      digest_low,
  output logic [polyval_pkg::WORD_W-1:0]      digest_high,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [polyval_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [polyval_pkg::WORD_W-1:0]      cfg_data
);
  import polyval_pkg::*;

  cmd_t cmd;

  polyval_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .last_block (last_block),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cmd        (cmd)
  );

  polyval_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .block_low   (block_low),
    .block_high  (block_high),
    .cfg_data    (cfg_data),
    .digest_low  (digest_low),
    .digest_high (digest_high)
  );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// POLYVAL hash accumulator regression
// Streams 128-bit blocks through the unit under random key settings and
// random handshake gaps, predicts each digest with a bit-serial GF(2^128)
// dot product, and checks every digest field against the prediction.
// ----------------------------------------------------------------------------
typedef logic [polyval_pkg::WORD_W-1:0]   word_t;
typedef logic [polyval_pkg::BLOCK_W-1:0]  block_t;
typedef logic [polyval_pkg::CFG_INDEX_W-1:0] reg_index_t;

class polyval_scoreboard;
  word_t  key_low;
  word_t  key_high;
  block_t acc;
  block_t digests_due[$];
  int     mismatches;

  function new();
    key_low    = '0;
    key_high   = '0;
    acc        = '0;
    mismatches = 0;
  endfunction

  // a * b * x^-128 mod x^128 + x^127 + x^126 + x^121 + 1
  static function block_t polyval_dot(block_t a, block_t b);
    logic [2*polyval_pkg::BLOCK_W-1:0] prod;
    logic [2*polyval_pkg::BLOCK_W-1:0] modulus;
    prod    = '0;
    modulus = '0;
    modulus[0]   = 1'b1;
    modulus[121] = 1'b1;
    modulus[126] = 1'b1;
    modulus[127] = 1'b1;
    modulus[128] = 1'b1;
    for (int k = 0; k < polyval_pkg::BLOCK_W; k++) begin
      if (a[k]) begin
        prod = prod ^ ({{polyval_pkg::BLOCK_W{1'b0}}, b} << k);
      end
    end
    for (int k = 0; k < polyval_pkg::BLOCK_W; k++) begin
      if (prod[0]) begin
        prod = prod ^ modulus;
      end
      prod = prod >> 1;
    end
    return prod[polyval_pkg::BLOCK_W-1:0];
  endfunction

  function void write_reg(reg_index_t index, word_t data);
    if (index == polyval_pkg::REG_KEY_LOW) begin
      key_low = data;
    end else if (index == polyval_pkg::REG_KEY_HIGH) begin
      key_high = data;
    end
  endfunction

  function void note_block(word_t lo, word_t hi, logic last);
    block_t next_acc;
    next_acc = polyval_dot(acc ^ {hi, lo}, {key_high, key_low});
    if (last) begin
      digests_due.push_back(next_acc);
      acc = '0;
    end else begin
      acc = next_acc;
    end
  endfunction

  function int pending();
    return digests_due.size();
  endfunction

  function void flag(string field, word_t want, word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: digest %s mismatch: expected %h, actual %h", $realtime, field, want, got);
    end
  endfunction

  function void check_digest(word_t lo, word_t hi);
    block_t want;
    if (digests_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected digest %h_%h", $realtime, hi, lo);
      end
      return;
    end
    want = digests_due.pop_front();
    if (lo !== want[polyval_pkg::WORD_W-1:0]) begin
      flag("low", want[polyval_pkg::WORD_W-1:0], lo);
    end
    if (hi !== want[polyval_pkg::BLOCK_W-1:polyval_pkg::WORD_W]) begin
      flag("high", want[polyval_pkg::BLOCK_W-1:polyval_pkg::WORD_W], hi);
    end
  endfunction
endclass

module tb_top;

  localparam int         SETTLE_CYCLES  = 16;
  localparam int         STALL_LIMIT    = 4000;
  localparam int         PHASES         = 12;
  localparam int         PHASE_ITEMS    = 50;
  localparam int         QUIET_PHASE    = 10;
  localparam word_t      ALL_ONES       = '1;
  localparam word_t      TOP_BIT        = word_t'(1) << (polyval_pkg::WORD_W - 1);
  localparam reg_index_t REG_INDEX_LAST = '1;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  word_t      block_low;
  word_t      block_high;
  logic       last_block;
  logic       out_valid;
  logic       out_ready;
  word_t      digest_low;
  word_t      digest_high;
  logic       cfg_valid;
  logic       cfg_ready;
  reg_index_t cfg_index;
  word_t      cfg_data;

  polyval_scoreboard sb;
  int in_gap_pct;
  int out_stall_pct;
  int idle_cycles;

  polyval_hash_accumulator_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .block_low   (block_low),
    .block_high  (block_high),
    .last_block  (last_block),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_low  (digest_low),
    .digest_high (digest_high),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return word_t'(1) << $urandom_range(0, polyval_pkg::WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_block(input word_t lo, input word_t hi, input logic last);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    block_low  <= lo;
    block_high <= hi;
    last_block <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_block(lo, hi, last);
  endtask

  task automatic write_reg(input reg_index_t index, input word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, data);
  endtask

  // drop valids, drain digests, then let the multiplier finish
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_key();
    word_t lo;
    word_t hi;
    case ($urandom_range(0, 5))
      0: begin lo = '0; hi = '0; end
      1: begin lo = ALL_ONES; hi = ALL_ONES; end
      2: begin lo = word_t'(1); hi = '0; end
      3: begin lo = '0; hi = TOP_BIT; end
      default: begin lo = rand_word(); hi = rand_word(); end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      write_reg(reg_index_t'($urandom_range(2, 255)), rand_word());
    end
    case ($urandom_range(0, 3))
      0: write_reg(polyval_pkg::REG_KEY_LOW, lo);
      1: write_reg(polyval_pkg::REG_KEY_HIGH, hi);
      2: begin
        write_reg(polyval_pkg::REG_KEY_HIGH, hi);
        write_reg(polyval_pkg::REG_KEY_LOW, lo);
      end
      default: begin
        write_reg(polyval_pkg::REG_KEY_LOW, lo);
        write_reg(polyval_pkg::REG_KEY_HIGH, hi);
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int   msg_len;
    int   msg_pos;
    logic last;
    sb            = new();
    in_gap_pct    = 25;
    out_stall_pct = 30;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    block_low  <= '0;
    block_high <= '0;
    last_block <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero key after reset
    send_block(ALL_ONES, ALL_ONES, 1'b1);
    send_block('0, '0, 1'b0);
    send_block(rand_word(), rand_word(), 1'b1);

    settle();
    write_reg(polyval_pkg::REG_KEY_LOW, word_t'(1));
    write_reg(polyval_pkg::REG_KEY_HIGH, '0);
    cfg_valid <= 1'b0;
    send_block('0, '0, 1'b1);
    send_block(ALL_ONES, '0, 1'b1);
    send_block('0, ALL_ONES, 1'b0);
    send_block(TOP_BIT, word_t'(1), 1'b1);

    settle();
    write_reg(polyval_pkg::REG_KEY_LOW, ALL_ONES);
    write_reg(polyval_pkg::REG_KEY_HIGH, ALL_ONES);
    cfg_valid <= 1'b0;
    send_block(ALL_ONES, ALL_ONES, 1'b0);
    send_block(rand_word(), rand_word(), 1'b1);

    // change the key in the middle of a message
    send_block(rand_word(), rand_word(), 1'b0);
    settle();
    write_reg(polyval_pkg::REG_KEY_HIGH, TOP_BIT);
    cfg_valid <= 1'b0;
    send_block(rand_word(), rand_word(), 1'b1);

    // writes to unknown indexes must leave the key alone
    settle();
    write_reg(REG_INDEX_LAST, ALL_ONES);
    write_reg(reg_index_t'(2), rand_word());
    write_reg(reg_index_t'($urandom_range(3, 254)), rand_word());
    cfg_valid <= 1'b0;
    send_block(rand_word(), rand_word(), 1'b0);
    send_block(rand_word(), rand_word(), 1'b1);

    msg_len = $urandom_range(1, 4);
    msg_pos = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase >= QUIET_PHASE) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = $urandom_range(0, 2) * 25;
        out_stall_pct = $urandom_range(0, 2) * 25;
      end
      pick_key();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        last = (msg_pos + 1 >= msg_len);
        send_block(rand_word(), rand_word(), last);
        if (last) begin
          msg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
          msg_pos = 0;
        end else begin
          msg_pos++;
        end
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("polyval_hash_accumulator_unit regression: pass");
    end else begin
      $display("polyval_hash_accumulator_unit regression: fail");
    end
    $finish;
  end

  initial begin
    out_ready <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_digest(digest_low, digest_high);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("polyval_hash_accumulator_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
